/* hdl/eirel_pkg.sv */
// types and constants shared by the relocation engine modules
// no dependencies
`default_nettype none

package eirel_pkg;

  localparam logic [15:0] SEC_COMMON = 16'd65522;
  localparam logic [7:0] TYPE_ABS32 = 8'd1;
  localparam logic [7:0] TYPE_PC32 = 8'd2;

  localparam int CFG_INDEX_W = 4;
  localparam logic [CFG_INDEX_W-1:0] CFG_TEXT_SEC = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RODATA_SEC = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_DATA_SEC = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_BSS_SEC = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_TEXT_BASE = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_RODATA_BASE = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_DATA_BASE = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_BSS_BASE = 4'd7;

  localparam logic [1:0] ST_APPLIED = 2'd0;
  localparam logic [1:0] ST_BAD_TYPE = 2'd1;
  localparam logic [1:0] ST_BAD_SECTION = 2'd2;
  localparam logic [1:0] ST_TABLE_FULL = 2'd3;

  localparam logic CMD_APPLY = 1'b0;
  localparam logic CMD_BEGIN = 1'b1;

  typedef struct packed {
    logic        command;
    logic [7:0]  rel_type;
    logic [23:0] sym_index;
    logic [15:0] sym_section;
    logic [31:0] sym_value;
    logic [31:0] sym_size;
    logic [31:0] rel_offset;
    logic [31:0] load_offset;
    logic [31:0] word_in;
    logic [31:0] common_start;
  } reloc_in_t;

  typedef struct packed {
    logic [31:0] target_address;
    logic [31:0] word_out;
    logic        write_enable;
    logic [1:0]  status;
  } reloc_out_t;

  typedef enum logic [1:0] {
    KIND_RESULT = 2'd0,
    KIND_BEGIN  = 2'd1,
    KIND_COMMON = 2'd2
  } kind_t;

  // one classified transaction between front and back
  typedef struct packed {
    kind_t       kind;
    logic [31:0] target_address;
    logic [31:0] data;
    logic        write_enable;
    logic [1:0]  status;
    logic [23:0] sym_index;
    logic [31:0] size_rounded;
  } queue_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic [23:0] sym_index;
    logic [31:0] offset;
  } common_entry_t;

endpackage

`default_nettype wire

/* hdl/eirel_ram.sv */
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module eirel_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hdl/eirel_front.sv */
// front part: section registers, command accept and classification
// depends on eirel_pkg
`default_nettype none

module eirel_front import eirel_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire reloc_in_t              item,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [31:0]            cfg_data,
  input  wire queue_status_t          qstat,
  output logic                        push,
  output queue_entry_t                push_data
);

  logic [15:0] sec_text, sec_rodata, sec_data, sec_bss;
  logic [31:0] base_text, base_rodata, base_data, base_bss;
  logic [31:0] base;
  logic        hit;

  assign cfg_ready = 1'b1;
  assign busy = qstat.full;
  assign push = start && !qstat.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      sec_text <= '0;
      sec_rodata <= '0;
      sec_data <= '0;
      sec_bss <= '0;
      base_text <= '0;
      base_rodata <= '0;
      base_data <= '0;
      base_bss <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TEXT_SEC:    sec_text <= cfg_data[15:0];
        CFG_RODATA_SEC:  sec_rodata <= cfg_data[15:0];
        CFG_DATA_SEC:    sec_data <= cfg_data[15:0];
        CFG_BSS_SEC:     sec_bss <= cfg_data[15:0];
        CFG_TEXT_BASE:   base_text <= cfg_data;
        CFG_RODATA_BASE: base_rodata <= cfg_data;
        CFG_DATA_BASE:   base_data <= cfg_data;
        CFG_BSS_BASE:    base_bss <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    base = '0;
    hit = 1'b0;
    priority if (item.sym_section == sec_text) begin
      base = base_text;
      hit = 1'b1;
    end else if (item.sym_section == sec_rodata) begin
      base = base_rodata;
      hit = 1'b1;
    end else if (item.sym_section == sec_data) begin
      base = base_data;
      hit = 1'b1;
    end else if (item.sym_section == sec_bss) begin
      base = base_bss;
      hit = 1'b1;
    end else begin
      base = '0;
      hit = 1'b0;
    end
  end

  always_comb begin
    push_data.kind = KIND_RESULT;
    push_data.target_address = item.load_offset + item.rel_offset;
    push_data.data = item.word_in;
    push_data.write_enable = 1'b0;
    push_data.status = ST_BAD_TYPE;
    push_data.sym_index = item.sym_index;
    push_data.size_rounded = (item.sym_size + 32'd3) & ~32'd3;
    if (item.command == CMD_BEGIN) begin
      push_data.kind = KIND_BEGIN;
      push_data.data = item.common_start;
    end else if (item.rel_type == TYPE_ABS32) begin
      if (item.sym_section == SEC_COMMON) begin
        push_data.kind = KIND_COMMON;
      end else begin
        push_data.data = base + item.sym_value + item.word_in;
        push_data.write_enable = 1'b1;
        push_data.status = hit ? ST_APPLIED : ST_BAD_SECTION;
      end
    end else if (item.rel_type == TYPE_PC32) begin
      push_data.data = item.sym_value + item.word_in - item.rel_offset;
      push_data.write_enable = 1'b1;
      push_data.status = ST_APPLIED;
    end
  end

endmodule

`default_nettype wire

/* hdl/eirel_queue.sv */
// two entry queue between front and back
// depends on eirel_pkg
`default_nettype none

module eirel_queue import eirel_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire queue_entry_t push_data,
  input  wire logic         pop,
  output queue_entry_t      head,
  output queue_status_t     qstat
);

  queue_entry_t slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fill;

  assign head = slots[rd_ptr];
  assign qstat.full = (fill == 2'd2);
  assign qstat.empty = (fill == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/eirel_back.sv */
// back part: common table scan and allocation, result register
// depends on eirel_pkg and eirel_ram
`default_nettype none

module eirel_back import eirel_pkg::*; #(
  parameter int COMMON_ENTRIES = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire queue_entry_t  head,
  input  wire queue_status_t qstat,
  output logic               pop,
  output logic               done,
  output reloc_out_t         result
);

  localparam int AW = (COMMON_ENTRIES > 1) ? $clog2(COMMON_ENTRIES) : 1;
  localparam int CW = $clog2(COMMON_ENTRIES + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_CMP   = 4'b0100,
    S_ALLOC = 4'b1000
  } state_t;

  state_t        state;
  queue_entry_t  cur;
  logic [AW-1:0] idx;
  logic [CW-1:0] count;
  logic [31:0]   next_off;
  logic          ram_we;
  common_entry_t ram_wdata, ram_rdata;
  logic          table_full;
  logic          last_entry;

  assign pop = (state == S_IDLE) && !qstat.empty;
  assign table_full = (count == CW'(COMMON_ENTRIES));
  assign last_entry = ((CW'(idx) + CW'(1)) == count);
  assign ram_we = (state == S_ALLOC) && !table_full;
  assign ram_wdata.sym_index = cur.sym_index;
  assign ram_wdata.offset = next_off;

  eirel_ram #(
    .WIDTH($bits(common_entry_t)),
    .DEPTH(COMMON_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count[AW-1:0]),
    .wdata(ram_wdata),
    .raddr(idx),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx <= '0;
      count <= '0;
      next_off <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            unique case (head.kind)
              KIND_BEGIN: begin
                count <= '0;
                next_off <= head.data;
              end
              KIND_COMMON: begin
                idx <= '0;
                state <= (count == '0) ? S_ALLOC : S_READ;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_READ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (ram_rdata.sym_index == cur.sym_index) begin
            done <= 1'b1;
            state <= S_IDLE;
          end else if (last_entry) begin
            state <= S_ALLOC;
          end else begin
            idx <= idx + AW'(1);
            state <= S_READ;
          end
        end
        S_ALLOC: begin
          done <= 1'b1;
          state <= S_IDLE;
          if (!table_full) begin
            count <= count + CW'(1);
            next_off <= next_off + cur.size_rounded;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        result.target_address <= head.target_address;
        result.word_out <= head.data;
        result.write_enable <= head.write_enable;
        result.status <= head.status;
      end
      S_CMP: begin
        result.target_address <= cur.target_address;
        result.word_out <= ram_rdata.offset;
        result.write_enable <= 1'b1;
        result.status <= ST_APPLIED;
      end
      S_ALLOC: begin
        result.target_address <= cur.target_address;
        result.word_out <= table_full ? cur.data : next_off;
        result.write_enable <= !table_full;
        result.status <= table_full ? ST_TABLE_FULL : ST_APPLIED;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* hdl/elf_i386_relocation_engine_unit.sv */
// top level of the elf32 i386 relocation engine
// depends on eirel_pkg, eirel_front, eirel_queue, eirel_back
//
// usage:
//   command channel: item is taken at a clock edge with start high and busy
//   low. an apply command gives exactly one result, a begin command none.
//   result channel: done is high for one cycle while result holds the
//   patched word, its address, write enable and status; it is not held.
//   config channel: cfg_valid writes cfg_data to register cfg_index; cfg_ready
//   is always high, indexes above 7 are dropped. write only while idle.
// throughput and flow:
//   a relocation that needs no common lookup passes through the queue to the
//   done and result registers, and such items flow at one per cycle while no
//   table walk is in progress. a common symbol walks the table one stored
//   entry at a time through the single read port of the table ram, over the
//   commons allocated since the last begin command.
//   a two entry queue sits between classification and table walk; busy is
//   high while it is full.
// reset: clears section registers, queue, common count and next offset;
//   the table ram needs no clearing since only entries below the count
//   are read.
`default_nettype none

module elf_i386_relocation_engine_unit import eirel_pkg::*; #(
  parameter int COMMON_ENTRIES = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire reloc_in_t              item,
  output logic                        done,
  output reloc_out_t                  result,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [31:0]            cfg_data
);

  queue_status_t qstat;
  queue_entry_t  push_data, head;
  logic          push, pop;

  eirel_front u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .item     (item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .qstat    (qstat),
    .push     (push),
    .push_data(push_data)
  );

  eirel_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  eirel_back #(
    .COMMON_ENTRIES(COMMON_ENTRIES)
  ) u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .qstat (qstat),
    .pop   (pop),
    .done  (done),
    .result(result)
  );

endmodule

`default_nettype wire

/* hdl/eirel_checker.sv */
// port level checks for the relocation engine, bound to the top level
// depends on eirel_pkg and elf_i386_relocation_engine_unit
`default_nettype none

module eirel_checker import eirel_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   start,
  input wire logic                   busy,
  input wire logic                   done,
  input wire reloc_out_t             result,
  input wire logic                   cfg_ready
);

  a_quiet_after_reset: assert property (@(posedge clk) rst |=> !done && !busy)
    else $error("done or busy right after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config channel not ready");

  a_no_write_status: assert property (@(posedge clk) disable iff (rst)
    done && !result.write_enable |->
      result.status == ST_BAD_TYPE || result.status == ST_TABLE_FULL)
    else $error("write suppressed with wrong status");

  a_bad_type_no_write: assert property (@(posedge clk) disable iff (rst)
    done && result.status == ST_BAD_TYPE |-> !result.write_enable)
    else $error("unknown type written back");

  a_busy_needs_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && !busy))
    else $error("busy rose without an accepted transaction");

endmodule

bind elf_i386_relocation_engine_unit eirel_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .result   (result),
  .cfg_ready(cfg_ready)
);

`default_nettype wire

/* tb/elf_i386_relocation_engine_unit_tb.sv */
// self-checking testbench for elf_i386_relocation_engine_unit: directed and random
// relocation commands checked against an in-bench prediction of the patched word
// depends on eirel_pkg and the relocation engine rtl
module elf_i386_relocation_engine_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import eirel_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 24;
  localparam int RANDOM_PHASES = 6;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  reloc_in_t item = '0;
  logic done;
  reloc_out_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // predicted engine state
  logic [15:0] sec_index_reg [4];
  logic [31:0] sec_base_reg [4];
  logic [23:0] common_sym_tbl [TABLE_DEPTH];
  logic [31:0] common_off_tbl [TABLE_DEPTH];
  bit common_used [TABLE_DEPTH];
  int common_count;
  logic [31:0] common_next;

  reloc_in_t reloc_q[$];
  reloc_out_t patch_q[$];
  int bad_fields = 0;
  bit taken = 1'b0;
  int burst_left = 0;
  int gap_left = 0;

  elf_i386_relocation_engine_unit #(
    .COMMON_ENTRIES(TABLE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .done(done),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  function automatic bit apply_relocation(input reloc_in_t it, output reloc_out_t r);
    logic [31:0] base;
    bit hit;
    bit found;
    r.target_address = it.load_offset + it.rel_offset;
    r.word_out = it.word_in;
    r.write_enable = 1'b0;
    r.status = ST_APPLIED;
    if (it.command == CMD_BEGIN) begin
      for (int k = 0; k < TABLE_DEPTH; k++) common_used[k] = 1'b0;
      common_count = 0;
      common_next = it.common_start;
      return 1'b0;
    end
    if (it.rel_type == TYPE_ABS32) begin
      if (it.sym_section == SEC_COMMON) begin
        found = 1'b0;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
          if (!found && common_used[k] && common_sym_tbl[k] == it.sym_index) begin
            found = 1'b1;
            r.word_out = common_off_tbl[k];
            r.write_enable = 1'b1;
          end
        end
        if (!found) begin
          if (common_count >= TABLE_DEPTH) begin
            r.status = ST_TABLE_FULL;
          end else begin
            common_sym_tbl[common_count] = it.sym_index;
            common_off_tbl[common_count] = common_next;
            common_used[common_count] = 1'b1;
            common_count++;
            r.word_out = common_next;
            r.write_enable = 1'b1;
            common_next = common_next + ((it.sym_size + 32'd3) & ~32'd3);
          end
        end
      end else begin
        base = '0;
        hit = 1'b0;
        for (int k = 0; k < 4; k++) begin
          if (!hit && it.sym_section == sec_index_reg[k]) begin
            base = sec_base_reg[k];
            hit = 1'b1;
          end
        end
        if (!hit) r.status = ST_BAD_SECTION;
        r.word_out = base + it.sym_value + it.word_in;
        r.write_enable = 1'b1;
      end
    end else if (it.rel_type == TYPE_PC32) begin
      r.word_out = it.sym_value + it.word_in - it.rel_offset;
      r.write_enable = 1'b1;
    end else begin
      r.status = ST_BAD_TYPE;
    end
    return 1'b1;
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] seen);
    if (seen !== want) begin
      bad_fields++;
      $display("%0t: %s expected %h actual %h", $time, field, want, seen);
    end
  endfunction

  function automatic reloc_in_t make_item(input logic cmd, input logic [7:0] typ,
                                          input logic [23:0] sym, input logic [15:0] sec,
                                          input logic [31:0] value, input logic [31:0] size,
                                          input logic [31:0] roff, input logic [31:0] loff,
                                          input logic [31:0] word, input logic [31:0] cstart);
    reloc_in_t it;
    it.command = cmd;
    it.rel_type = typ;
    it.sym_index = sym;
    it.sym_section = sec;
    it.sym_value = value;
    it.sym_size = size;
    it.rel_offset = roff;
    it.load_offset = loff;
    it.word_in = word;
    it.common_start = cstart;
    return it;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_size();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return $urandom_range(0, 16);
      6, 7: return $urandom_range(0, 4096);
      default: return rand_word();
    endcase
  endfunction

  // monitor: result check, config and command transaction capture
  always @(posedge clk) begin : watch
    reloc_out_t want;
    reloc_out_t seen;
    taken = 1'b0;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index <= CFG_BSS_SEC) begin
          sec_index_reg[cfg_index[1:0]] = cfg_data[15:0];
        end else if (cfg_index <= CFG_BSS_BASE) begin
          sec_base_reg[cfg_index[1:0]] = cfg_data;
        end
      end
      if (done) begin
        seen = result;
        if (patch_q.size() == 0) begin
          bad_fields++;
          $display("%0t: unexpected result, expected none actual %h", $time, seen);
        end else begin
          want = patch_q.pop_front();
          check_field("target_address", want.target_address, seen.target_address);
          check_field("word_out", want.word_out, seen.word_out);
          check_field("write_enable", 32'(want.write_enable), 32'(seen.write_enable));
          check_field("status", 32'(want.status), 32'(seen.status));
        end
      end
      if (start && !busy) begin
        taken = 1'b1;
        if (apply_relocation(item, want)) patch_q.push_back(want);
      end
    end
  end

  // driver: bursts of commands with random gaps
  always @(negedge clk) begin : drive
    logic next_start;
    reloc_in_t next_item;
    next_start = start && !taken;
    next_item = item;
    if (!next_start) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (reloc_q.size() > 0) begin
        next_item = reloc_q.pop_front();
        next_start = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 8);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
    start <= next_start;
    item <= next_item;
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_sections(input logic [3:0][15:0] secs, input logic [3:0][31:0] bases);
    for (int k = 0; k < 4; k++) begin
      write_reg(CFG_TEXT_SEC + CFG_INDEX_W'(k), {16'($urandom), secs[k]});
    end
    for (int k = 0; k < 4; k++) write_reg(CFG_TEXT_BASE + CFG_INDEX_W'(k), bases[k]);
    // index past the last register, dropped
    write_reg(CFG_BSS_BASE + CFG_INDEX_W'(1 + $urandom_range(0, 7)), $urandom);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    while (reloc_q.size() != 0 || start || patch_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_random(input int count, input int common_pct, input int begin_odds,
                              input int sym_pool);
    reloc_in_t it;
    int pick;
    for (int n = 0; n < count; n++) begin
      it.command = ($urandom_range(0, begin_odds) == 0) ? CMD_BEGIN : CMD_APPLY;
      pick = $urandom_range(0, 99);
      if (pick < 50) it.rel_type = TYPE_ABS32;
      else if (pick < 75) it.rel_type = TYPE_PC32;
      else it.rel_type = 8'($urandom);
      if ($urandom_range(0, 99) < common_pct) it.sym_section = SEC_COMMON;
      else if ($urandom_range(0, 2) != 0) it.sym_section = sec_index_reg[2'($urandom_range(0, 3))];
      else it.sym_section = 16'($urandom);
      pick = $urandom_range(0, 9);
      if (pick == 0) it.sym_index = 24'($urandom);
      else if (pick == 1) it.sym_index = 24'hFFFFFF - 24'($urandom_range(0, 3));
      else it.sym_index = 24'($urandom_range(0, sym_pool - 1));
      it.sym_value = rand_word();
      it.sym_size = rand_size();
      it.rel_offset = rand_word();
      it.load_offset = rand_word();
      it.word_in = rand_word();
      it.common_start = rand_word();
      reloc_q.push_back(it);
    end
  endtask

  initial begin : stimulus
    logic [3:0][15:0] secs;
    logic [3:0][31:0] bases;
    for (int k = 0; k < 4; k++) begin
      sec_index_reg[k] = '0;
      sec_base_reg[k] = '0;
    end
    for (int k = 0; k < TABLE_DEPTH; k++) common_used[k] = 1'b0;
    common_count = 0;
    common_next = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // rodata and data share an index so the first match decides
    secs = {16'hFFFF, 16'd2, 16'd2, 16'd1};
    bases = {32'h8000_0000, 32'h1234_5678, 32'hFFFF_FFFF, 32'h0040_0000};
    program_sections(secs, bases);

    reloc_q.push_back(make_item(CMD_BEGIN, TYPE_ABS32, '0, SEC_COMMON, '0, '0, '0, '0, '0,
                                32'hFFFF_FFF8));
    reloc_q.push_back(make_item(CMD_APPLY, TYPE_ABS32, 24'd1, 16'd1, '0, '0, '0, '0, '0, '0));
    reloc_q.push_back(make_item(CMD_APPLY, TYPE_ABS32, 24'd2, 16'd2, '1, '0, '1, 32'd1, '1,
                                '0));
    reloc_q.push_back(make_item(CMD_APPLY, TYPE_ABS32, 24'd3, 16'hFFFF, 32'h7FFF_FFFF, '0,
                                32'h40, 32'h1000, 32'd1, '0));
    reloc_q.push_back(make_item(CMD_APPLY, TYPE_ABS32, 24'd4, 16'd3, 32'h1000, '0, 32'h8,
                                32'h2000, 32'h20, '0));
    reloc_q.push_back(make_item(CMD_APPLY, TYPE_ABS32, 24'd4, 16'd0, 32'hDEAD_0000, '0, '0,
                                '0, 32'hBEEF, '0));
    // commons: wrap of the next offset and of the size rounding
    reloc_q.push_back(make_item(CMD_APPLY, TYPE_ABS32, 24'd5, SEC_COMMON, '1, 32'd5, 32'h10,
                                '0, 32'h55, '1));
    reloc_q.push_back(make_item(CMD_APPLY, TYPE_ABS32, 24'hFFFFFF, SEC_COMMON, '0, '1, '0, '0,
                                '1, '0));
    reloc_q.push_back(make_item(CMD_APPLY, TYPE_ABS32, 24'd0, SEC_COMMON, '0, '0, '0, '0, '0,
                                '0));
    reloc_q.push_back(make_item(CMD_APPLY, TYPE_ABS32, 24'd5, SEC_COMMON, '0, 32'd100, '0, '0,
                                '0, '0));
    reloc_q.push_back(make_item(CMD_APPLY, TYPE_ABS32, 24'd7, SEC_COMMON, '0, 32'd1, '0, '0,
                                '0, '0));
    reloc_q.push_back(make_item(CMD_APPLY, TYPE_PC32, 24'd8, 16'd1, '0, '0, 32'd1, '0, '0,
                                '0));
    reloc_q.push_back(make_item(CMD_APPLY, TYPE_PC32, 24'd8, 16'd9, '1, '1, '0, '1, '1, '1));
    reloc_q.push_back(make_item(CMD_APPLY, TYPE_PC32, 24'd5, SEC_COMMON, 32'h100, 32'd4,
                                32'h80, 32'h4000, 32'h3, '0));
    reloc_q.push_back(make_item(CMD_APPLY, 8'd0, 24'd9, 16'd1, '1, '0, 32'h4, 32'h8, 32'hA5,
                                '0));
    reloc_q.push_back(make_item(CMD_APPLY, 8'd3, 24'd9, 16'd2, '1, '0, 32'h4, 32'h8, 32'h5A,
                                '0));
    reloc_q.push_back(make_item(CMD_APPLY, 8'hFF, 24'd11, SEC_COMMON, '0, 32'd8, '0, '0,
                                32'h77, '0));
    reloc_q.push_back(make_item(CMD_BEGIN, TYPE_ABS32, 24'd5, SEC_COMMON, '1, '1, '1, '1, '1,
                                '0));
    reloc_q.push_back(make_item(CMD_APPLY, TYPE_ABS32, 24'd5, SEC_COMMON, '0, 32'd2, '0, '0,
                                '0, '0));
    reloc_q.push_back(make_item(CMD_APPLY, TYPE_ABS32, 24'hFFFFFF, 16'hFFFF, '1, '1, '1, '1,
                                '1, '1));
    reloc_q.push_back(make_item(CMD_APPLY, TYPE_PC32, 24'd1, 16'd1, 32'd4, '0, 32'd1, '1,
                                32'd8, '0));
    reloc_q.push_back(make_item(CMD_BEGIN, '0, '0, '0, '0, '0, '0, '0, '0, '1));
    reloc_q.push_back(make_item(CMD_APPLY, TYPE_ABS32, 24'hABCDEF, SEC_COMMON, '0, 32'd3, '0,
                                '0, '0, '0));

    // fill the common table, then overflow it and look up stored entries
    reloc_q.push_back(make_item(CMD_BEGIN, '0, '0, '0, '0, '0, '0, '0, '0, 32'h0000_1000));
    for (int i = 0; i < TABLE_DEPTH + 2; i++) begin
      reloc_q.push_back(make_item(CMD_APPLY, TYPE_ABS32, 24'(i * 977 + 3), SEC_COMMON,
                                  $urandom, $urandom_range(0, 64), $urandom, $urandom,
                                  $urandom, '0));
    end
    reloc_q.push_back(make_item(CMD_APPLY, TYPE_ABS32, 24'd3, SEC_COMMON, '0, '0, '0, '0,
                                $urandom, '0));
    reloc_q.push_back(make_item(CMD_APPLY, TYPE_ABS32, 24'((TABLE_DEPTH - 1) * 977 + 3),
                                SEC_COMMON, '0, '0, '0, '0, $urandom, '0));
    reloc_q.push_back(make_item(CMD_APPLY, TYPE_ABS32, 24'd1, 16'd1, $urandom, '0, '0, '0,
                                $urandom, '0));
    settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          secs = '0;
          bases = '0;
        end
        1: begin
          secs = '1;
          bases = '1;
        end
        2: begin
          for (int k = 0; k < 4; k++) begin
            secs[k] = 16'($urandom_range(0, 7));
            bases[k] = $urandom;
          end
          // common is tested ahead of a section register holding the same index
          secs[0] = SEC_COMMON;
        end
        default: begin
          for (int k = 0; k < 4; k++) begin
            secs[k] = (p == 4) ? 16'($urandom) : 16'($urandom_range(0, 7));
            bases[k] = $urandom;
          end
        end
      endcase
      program_sections(secs, bases);
      if (p == 3) queue_random(200, 90, 2000, 300);
      else queue_random(120, 35, 30, 80);
      settle();
    end

    if (bad_fields == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* sim.f */
hdl/eirel_pkg.sv
hdl/eirel_ram.sv
hdl/eirel_front.sv
hdl/eirel_queue.sv
hdl/eirel_back.sv
hdl/elf_i386_relocation_engine_unit.sv
hdl/eirel_checker.sv
tb/elf_i386_relocation_engine_unit_tb.sv
